// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/gpp_pkg.sv -----
// ---------------------------------------------------------------------------
// gpp_pkg
// Types and constants of the GBM price path step block.
// ---------------------------------------------------------------------------
`default_nettype none

package gpp_pkg;

    localparam int unsigned CFG_AW = 2;

    localparam logic [CFG_AW-1:0] CFG_DRIFT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SCALE = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_START = 2'd2;

    // ln 2 in Q8.24
    localparam logic [24:0] LN2 = 25'd11629080;
    // floor(2^52 / LN2), LN2 being the Q8.24 constant above
    localparam logic [28:0] K_RECIP = 29'((64'd1 << 52) / 64'd11629080);
    // 1.0 in Q2.30
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [3:0]  EXP_TERMS = 4'd12;

    typedef struct packed {
        logic signed [31:0] log_sum;
        logic               sat;
        logic               last;
    } t_gpp_item;

    localparam logic [63:0] RECIP_BASE = 64'd1 << 32;

    // floor(2^32 / n) for the Horner divisors, n = 2..12
    function automatic logic [31:0] recip(input logic [3:0] n);
        logic [31:0] v;
        case (n)
            4'd2:    v = 32'(RECIP_BASE / 64'd2);
            4'd3:    v = 32'(RECIP_BASE / 64'd3);
            4'd4:    v = 32'(RECIP_BASE / 64'd4);
            4'd5:    v = 32'(RECIP_BASE / 64'd5);
            4'd6:    v = 32'(RECIP_BASE / 64'd6);
            4'd7:    v = 32'(RECIP_BASE / 64'd7);
            4'd8:    v = 32'(RECIP_BASE / 64'd8);
            4'd9:    v = 32'(RECIP_BASE / 64'd9);
            4'd10:   v = 32'(RECIP_BASE / 64'd10);
            4'd11:   v = 32'(RECIP_BASE / 64'd11);
            4'd12:   v = 32'(RECIP_BASE / 64'd12);
            default: v = 32'hFFFF_FFFF;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gpp_front.sv -----
// ---------------------------------------------------------------------------
// gpp_front
// Takes input items, scales the sample and updates the running log price.
// ---------------------------------------------------------------------------
`default_nettype none

module gpp_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [gpp_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [31:0]                 i_cfg_wdata,
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire logic signed [15:0]          i_normal_sample,
    input  wire logic                        i_first_step,
    input  wire logic                        i_last_step,
    output logic                             o_q_push,
    output gpp_pkg::t_gpp_item               o_q_item,
    input  wire logic                        i_q_full
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM} t_state;

    t_state             r_state;
    logic signed [31:0] r_drift;
    logic [30:0]        r_scale;
    logic signed [31:0] r_start;
    logic signed [31:0] r_log;
    logic signed [15:0] r_sample;
    logic               r_first;
    logic               r_last;
    logic signed [47:0] r_prod;

    logic signed [47:0] n_round;
    logic signed [37:0] n_sum;
    logic signed [31:0] n_clip;
    logic               n_sat;

    always_comb begin
        n_round = (r_prod + 48'sd2048) >>> 12;
        n_sum   = 38'(r_first ? r_start : r_log) + 38'(r_drift) + 38'(n_round);
        n_sat   = 1'b0;
        n_clip  = n_sum[31:0];
        if (n_sum > 38'sh0_7FFF_FFFF) begin
            n_clip = 32'sh7FFF_FFFF;
            n_sat  = 1'b1;
        end else if (n_sum < -38'sh0_8000_0000) begin
            n_clip = 32'sh8000_0000;
            n_sat  = 1'b1;
        end
    end

    assign o_full           = (r_state != S_IDLE);
    assign o_q_push         = (r_state == S_SUM) && !i_q_full;
    assign o_q_item.log_sum = n_clip;
    assign o_q_item.sat     = n_sat;
    assign o_q_item.last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drift <= '0;
            r_scale <= '0;
            r_start <= '0;
            r_log   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    gpp_pkg::CFG_DRIFT: r_drift <= i_cfg_wdata;
                    gpp_pkg::CFG_SCALE: r_scale <= i_cfg_wdata[30:0];
                    gpp_pkg::CFG_START: r_start <= i_cfg_wdata;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_sample <= i_normal_sample;
                        r_first  <= i_first_step;
                        r_last   <= i_last_step;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= $signed({1'b0, r_scale}) * r_sample;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (!i_q_full) begin
                        r_log   <= n_clip;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gpp_queue.sv -----
// ---------------------------------------------------------------------------
// gpp_queue
// Two-entry queue of log sums between the front and the exp unit.
// ---------------------------------------------------------------------------
`default_nettype none

module gpp_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  gpp_pkg::t_gpp_item      i_item,
    output logic                    o_full,
    input  wire logic               i_pop,
    output gpp_pkg::t_gpp_item      o_item,
    output logic                    o_empty
);

    gpp_pkg::t_gpp_item r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gpp_exp.sv -----
// ---------------------------------------------------------------------------
// gpp_exp
// Sequential exp unit: range reduction, 12-term Horner series, final shift,
// and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gpp_exp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  gpp_pkg::t_gpp_item      i_item,
    input  wire logic               i_q_empty,
    output logic                    o_q_pop,
    output logic [31:0]             o_price,
    output logic                    o_path_end,
    output logic                    o_saturated,
    output logic                    o_empty,
    input  wire logic               i_pop
);

    typedef enum logic [2:0] {
        S_IDLE, S_KMUL, S_KREM, S_KFIX, S_HMUL, S_HDIV, S_HFIX, S_SHIFT
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_l;
    logic               r_sat;
    logic               r_last;
    logic signed [61:0] r_kprod;
    logic signed [9:0]  r_q;
    logic signed [35:0] r_rem;
    logic [29:0]        r_r30;
    logic [31:0]        r_t;
    logic [3:0]         r_n;
    logic [63:0]        r_p;
    logic [31:0]        r_x;
    logic [63:0]        r_qm;
    logic               r_out_valid;
    logic [31:0]        r_price;
    logic               r_path_end;
    logic               r_saturated;

    logic [31:0]        n_hq;
    logic [35:0]        n_hrem;
    logic [32:0]        n_up;
    logic [7:0]         n_s;
    logic [47:0]        n_dn;
    logic [31:0]        n_price;
    logic               n_psat;

    always_comb begin
        n_hq   = (r_n == 4'd1) ? r_x : r_qm[63:32];
        n_hrem = {4'b0, r_x} - (36'(n_hq) * 36'(r_n));
        if (n_hrem >= 36'(r_n)) n_hq = n_hq + 32'd1;
    end

    always_comb begin
        n_up    = {1'b0, r_t} << r_q[0];
        n_s     = 8'(10'sd14 - r_q);
        n_dn    = ({16'b0, r_t} + (48'd1 << (n_s - 8'd1))) >> n_s;
        n_psat  = 1'b0;
        if (r_q >= 10'sd16) begin
            n_price = 32'hFFFF_FFFF;
            n_psat  = 1'b1;
        end else if (r_q >= 10'sd14) begin
            n_price = n_up[31:0];
            if (n_up[32]) begin
                n_price = 32'hFFFF_FFFF;
                n_psat  = 1'b1;
            end
        end else if (n_s > 8'd40) begin
            n_price = '0;
        end else begin
            n_price = n_dn[31:0];
        end
    end

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty     = !r_out_valid;
    assign o_price     = r_price;
    assign o_path_end  = r_path_end;
    assign o_saturated = r_saturated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_l     <= i_item.log_sum;
                        r_sat   <= i_item.sat;
                        r_last  <= i_item.last;
                        r_state <= S_KMUL;
                    end
                end
                S_KMUL: begin
                    r_kprod <= r_l * $signed({1'b0, gpp_pkg::K_RECIP});
                    r_state <= S_KREM;
                end
                S_KREM: begin
                    r_q     <= r_kprod[61:52];
                    r_rem   <= 36'(r_l) - $signed(r_kprod[61:52])
                               * $signed({1'b0, gpp_pkg::LN2});
                    r_state <= S_KFIX;
                end
                S_KFIX: begin
                    if (r_rem < 36'sd0) begin
                        r_q   <= r_q - 10'sd1;
                        r_r30 <= {24'(r_rem + 36'(gpp_pkg::LN2)), 6'b0};
                    end else if (r_rem >= 36'(gpp_pkg::LN2)) begin
                        r_q   <= r_q + 10'sd1;
                        r_r30 <= {24'(r_rem - 36'(gpp_pkg::LN2)), 6'b0};
                    end else begin
                        r_r30 <= {r_rem[23:0], 6'b0};
                    end
                    r_t     <= gpp_pkg::ONE_Q30;
                    r_n     <= gpp_pkg::EXP_TERMS;
                    r_state <= S_HMUL;
                end
                S_HMUL: begin
                    r_p     <= r_t * 64'(r_r30);
                    r_state <= S_HDIV;
                end
                S_HDIV: begin
                    r_x     <= r_p[61:30];
                    r_qm    <= 64'(r_p[61:30]) * 64'(gpp_pkg::recip(r_n));
                    r_state <= S_HFIX;
                end
                S_HFIX: begin
                    r_t <= gpp_pkg::ONE_Q30 + n_hq;
                    if (r_n == 4'd1) begin
                        r_state <= S_SHIFT;
                    end else begin
                        r_n     <= r_n - 4'd1;
                        r_state <= S_HMUL;
                    end
                end
                S_SHIFT: begin
                    if (!r_out_valid) begin
                        r_price     <= n_price;
                        r_path_end  <= r_last;
                        r_saturated <= r_sat | n_psat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_held, i_clk, i_rst_n, (r_out_valid && !i_pop) |=> r_out_valid, "result dropped")
    `ASSERT_CLK(a_term, i_clk, i_rst_n, (r_state == S_HFIX) |-> (r_n >= 4'd1 && r_n <= 4'd12), "bad term")
    `ASSERT_NEVER(a_pop, i_clk, i_rst_n, o_q_pop && i_q_empty, "pop from empty queue")

endmodule

`default_nettype wire

// ----- hw/rtl/gbm_price_path_step.sv -----
// ---------------------------------------------------------------------------
// gbm_price_path_step
// Geometric Brownian motion price path, one price per normal sample.
// ---------------------------------------------------------------------------
// Input channel: push/full. Each item is a Q4.12 normal sample plus
// first_step/last_step flags. Result channel: empty/pop; a result is a
// Q16.16 price, path_end (echo of last_step) and a saturation flag.
// Registers drift, shock scale and start log price are written through
// i_cfg_we/i_cfg_addr/i_cfg_wdata; the user must write them only while the
// block is idle, as the block does not enforce it. The front takes one item
// at a time and holds full high until it is done (multiply, then log sum
// and clip; the log sum feeds the next item); it stalls while the queue is
// full. A 2-entry queue feeds the exp unit, which also takes one item at a
// time: it pops an item, then does range reduction, the Horner steps
// (multiply, divide, fix) over 12 terms and the final shift to the result.
// Reset clears registers, log price and queue, and empties the result.
// If the result is not popped, the exp unit holds its next result and the
// queue fills; the front then stalls with full high.
// ---------------------------------------------------------------------------
`default_nettype none

module gbm_price_path_step (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [gpp_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [31:0]                 i_cfg_wdata,
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire logic signed [15:0]          i_normal_sample,
    input  wire logic                        i_first_step,
    input  wire logic                        i_last_step,
    output logic                             o_empty,
    input  wire logic                        i_pop,
    output logic [31:0]                      o_price,
    output logic                             o_path_end,
    output logic                             o_saturated
);

    gpp_pkg::t_gpp_item w_push_item;
    gpp_pkg::t_gpp_item w_pop_item;
    logic               w_q_push;
    logic               w_q_full;
    logic               w_q_pop;
    logic               w_q_empty;

    gpp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_normal_sample (i_normal_sample),
        .i_first_step    (i_first_step),
        .i_last_step     (i_last_step),
        .o_q_push        (w_q_push),
        .o_q_item        (w_push_item),
        .i_q_full        (w_q_full)
    );

    gpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_item  (w_pop_item),
        .o_empty (w_q_empty)
    );

    gpp_exp u_exp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_pop_item),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .o_price     (o_price),
        .o_path_end  (o_path_end),
        .o_saturated (o_saturated),
        .o_empty     (o_empty),
        .i_pop       (i_pop)
    );

endmodule

`default_nettype wire
